// ----- hdl/mexp_pkg.sv -----
// shared types and constants for the modular exponentiation block
// no dependencies
package mexp_pkg;

    localparam int BASE_W       = 64;
    localparam int EXP_W        = 32;
    localparam int OUT_W        = 32;
    localparam int CFG_W        = 32;
    localparam int DEF_MOD_BITS = 32;
    localparam int DEF_EXP_BITS = 32;
    localparam int CNT_W        = $clog2(BASE_W + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RBASE,
        ST_BIT,
        ST_LDA,
        ST_WA,
        ST_SQ,
        ST_LDB,
        ST_WB,
        ST_DONE
    } mexp_state_t;

    // request to the shared reduction unit
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] nbits;
    } red_req_t;

endpackage

// ----- hdl/mexp_cell.sv -----
// one exponent bit cell of the shifting exponent chain
// depends on mexp_pkg
module mexp_cell
    import mexp_pkg::*;
(
    input  logic aclk,
    input  logic load,
    input  logic load_bit,
    input  logic shift,
    input  logic shift_in,
    output logic bit_out
);

    logic bit_reg;

    // load from the input beat or take the neighbor's bit
    always_ff @(posedge aclk) begin
        if (load) begin
            bit_reg <= load_bit;
        end else if (shift) begin
            bit_reg <= shift_in;
        end
    end

    assign bit_out = bit_reg;

endmodule

// ----- hdl/mexp_modred.sv -----
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on mexp_pkg
module mexp_modred
    import mexp_pkg::*;
#(
    parameter int MOD_BITS = DEF_MOD_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  red_req_t            req,
    input  logic [BASE_W-1:0]   value,
    input  logic [MOD_BITS-1:0] modulus,
    output logic                done,
    output logic [MOD_BITS-1:0] rem
);

    logic [BASE_W-1:0]   val_reg;
    logic [MOD_BITS-1:0] rem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [MOD_BITS:0]   trial;
    logic [MOD_BITS:0]   diff;
    logic [MOD_BITS-1:0] rem_step;

    // shift in next bit, subtract modulus when it fits
    always_comb begin
        trial    = {rem_reg, val_reg[BASE_W-1]};
        diff     = trial - {1'b0, modulus};
        rem_step = (trial >= {1'b0, modulus}) ? diff[MOD_BITS-1:0] : trial[MOD_BITS-1:0];
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            val_reg <= value;
            rem_reg <= '0;
            cnt_reg <= req.nbits;
        end else if (busy_reg) begin
            val_reg <= val_reg << 1;
            rem_reg <= rem_step;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- hdl/modular_exponentiation.sv -----
// modular exponentiation top level: sequencer, multiplier, exponent chain
// depends on mexp_pkg, mexp_cell, mexp_modred
//
// usage:
//   cfg_wen/cfg_wdata write the modulus (low MOD_BITS bits), reset value 1.
//   s_ channel: one beat carries base (tdata[63:0]) and exponent
//   (tdata[95:64]); m_ channel returns base^exponent mod modulus.
//   one item is worked on at a time; s_tready is high only while idle.
//   work: base reduction of 64 dividend bits, then, for each of EXP_BITS
//   exponent bits, a squaring and (for a one bit) a multiply, each a
//   multiplier step, a load state and a 2*MOD_BITS bit pass through the
//   shared bit-serial remainder unit.
//   a zero reduced base or zero modulus finishes right after the base
//   reduction with result 0.
//   the result sits in an output register; while the receiver stalls that
//   register holds it, the next beat is still taken and its result waits
//   in the sequencer until the output register is free.
//   reset clears the sequencer, the output valid and sets modulus to 1.
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int MOD_BITS = DEF_MOD_BITS,
    parameter int EXP_BITS = DEF_EXP_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wen,
    input  logic [CFG_W-1:0]        cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [BASE_W+EXP_W-1:0] s_tdata,   // base[63:0], exponent[95:64]
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_W-1:0]        m_tdata    // power_mod[31:0]
);

    localparam int ECNT_W = $clog2(EXP_BITS + 1);
    localparam int PROD_W = 2 * MOD_BITS;

    mexp_state_t         state_reg, state_next;
    logic [MOD_BITS-1:0] mod_reg;
    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [MOD_BITS-1:0] b_reg, b_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [MOD_BITS-1:0] res_reg, res_next;
    logic [ECNT_W-1:0]   ecnt_reg, ecnt_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                accept;
    logic                cell_shift;
    logic [EXP_BITS-1:0] ebit;
    red_req_t            req;
    logic [BASE_W-1:0]   red_value;
    logic                red_done;
    logic [MOD_BITS-1:0] red_rem;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // exponent chain, bit 0 is the current bit
    genvar gi;
    generate
        for (gi = 0; gi < EXP_BITS; gi++) begin : g_cell
            logic lb;
            logic si;
            if (gi < EXP_W) begin : g_ld
                assign lb = s_tdata[BASE_W+gi];
            end else begin : g_zero
                assign lb = 1'b0;
            end
            if (gi == EXP_BITS - 1) begin : g_last
                assign si = 1'b0;
            end else begin : g_mid
                assign si = ebit[gi+1];
            end
            mexp_cell u_cell (
                .aclk     (aclk),
                .load     (accept),
                .load_bit (lb),
                .shift    (cell_shift),
                .shift_in (si),
                .bit_out  (ebit[gi])
            );
        end
    endgenerate

    // shared remainder unit request
    always_comb begin
        req.start = accept || state_reg == ST_LDA || state_reg == ST_LDB;
        if (accept) begin
            req.nbits = CNT_W'(BASE_W);
            red_value = s_tdata[BASE_W-1:0];
        end else begin
            req.nbits = CNT_W'(PROD_W);
            red_value = BASE_W'(prod_reg) << (BASE_W - PROD_W);
        end
    end

    mexp_modred #(
        .MOD_BITS (MOD_BITS)
    ) u_modred (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .value   (red_value),
        .modulus (mod_reg),
        .done    (red_done),
        .rem     (red_rem)
    );

    // sequencer next state and datapath
    always_comb begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        b_next        = b_reg;
        prod_next     = prod_reg;
        res_next      = res_reg;
        ecnt_next     = ecnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        cell_shift    = 1'b0;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RBASE;
                end
            end
            ST_RBASE: begin
                if (red_done) begin
                    b_next    = red_rem;
                    acc_next  = MOD_BITS'(1);
                    ecnt_next = '0;
                    if (red_rem == '0 || mod_reg == '0) begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_BIT;
                    end
                end
            end
            ST_BIT: begin
                if (ecnt_reg == ECNT_W'(EXP_BITS)) begin
                    res_next   = acc_reg;
                    state_next = ST_DONE;
                end else if (ebit[0]) begin
                    prod_next  = acc_reg * b_reg;
                    state_next = ST_LDA;
                end else begin
                    state_next = ST_SQ;
                end
            end
            ST_LDA: begin
                state_next = ST_WA;
            end
            ST_WA: begin
                if (red_done) begin
                    acc_next   = red_rem;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                prod_next  = b_reg * b_reg;
                state_next = ST_LDB;
            end
            ST_LDB: begin
                state_next = ST_WB;
            end
            ST_WB: begin
                if (red_done) begin
                    b_next     = red_rem;
                    cell_shift = 1'b1;
                    ecnt_next  = ecnt_reg + ECNT_W'(1);
                    state_next = ST_BIT;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'(res_reg);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers and modulus
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            mod_reg      <= MOD_BITS'(1);
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wen) begin
                mod_reg <= cfg_wdata[MOD_BITS-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        acc_reg     <= acc_next;
        b_reg       <= b_next;
        prod_reg    <= prod_next;
        res_reg     <= res_next;
        ecnt_reg    <= ecnt_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
